FILE: rtl/core/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared constants for the UTF-8 stream decoder: code width, byte class
// masks and payload masks of lead and continuation bytes.
// ----------------------------------------------------------------------------
package u8d_pkg;

   // width of a decoded code point
   localparam int unsigned CODE_BITS = 21;

   // byte class masks and match values
   localparam logic [7:0] TOP1_MASK  = 8'h80;
   localparam logic [7:0] TOP2_MASK  = 8'hC0;
   localparam logic [7:0] TOP3_MASK  = 8'hE0;
   localparam logic [7:0] TOP4_MASK  = 8'hF0;
   localparam logic [7:0] TOP5_MASK  = 8'hF8;
   localparam logic [7:0] CONT_MATCH = 8'h80;
   localparam logic [7:0] LEAD2_MATCH = 8'hC0;
   localparam logic [7:0] LEAD3_MATCH = 8'hE0;
   localparam logic [7:0] LEAD4_MATCH = 8'hF0;

   // payload bits of each byte kind
   localparam logic [7:0] CONT_BITS  = 8'h3F;
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;

   // utf8_mode register values
   localparam logic MODE_PASS = 1'b0;
   localparam logic MODE_UTF8 = 1'b1;

endpackage

FILE: rtl/core/u8d_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_rsp_queue
// Four-entry result queue. Takes zero, one or two words per cycle and hands
// out one word per cycle while out_ready is high; room2 says two more words fit.
// ----------------------------------------------------------------------------
module u8d_rsp_queue #(
   parameter int unsigned WIDTH = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push0,
   input  logic             push1,
   input  logic [WIDTH-1:0] data0,
   input  logic [WIDTH-1:0] data1,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data,
   output logic             room2
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop;
   logic [PW-1:0]    wptr_plus1;

   assign out_valid  = (count_ff != '0);
   assign out_data   = entry_ff[rptr_ff];
   assign pop        = out_valid && out_ready;
   assign room2      = (count_ff <= CW'(DEPTH - 2));
   assign wptr_plus1 = wptr_ff + PW'(1);

   // pointer and fill count update
   always_comb begin
      wptr_in  = wptr_ff + PW'(push0) + PW'(push1);
      rptr_in  = rptr_ff + PW'(pop);
      count_in = count_ff + CW'(push0) + CW'(push1) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage, second word goes right after the first
   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wptr_ff] <= data0;
      end
      if (push1) begin
         entry_ff[wptr_plus1] <= data1;
      end
   end

endmodule

FILE: rtl/core/utf8_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Decodes a byte stream as UTF-8 (or passes bytes through) and emits one
// word per character with its character index and start byte offset.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+----------------------------------
//   req     | in  | req_valid/req_ready  | data_byte, start_of_text
//   rsp     | out | rsp_valid/rsp_ready  | code_point, bad_sequence,
//           |     |                      | char_index, start_offset, last
//   csr     | in  | csr_valid/csr_ready  | utf8_mode
//
// One byte per cycle while req_ready is high: a byte is decoded in the cycle
// it is accepted; its results go to a four-entry register queue feeding rsp.
// A byte can give up to two words; req_ready is high while two slots are free.
// With rsp_ready held high the queue never fills and the input never stalls.
// Synchronous reset clears state and queue and sets utf8_mode to decode.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core #(
   parameter int unsigned INDEX_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_start_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u8d_pkg::CODE_BITS-1:0] rsp_code_point,
   output logic                          rsp_bad_sequence,
   output logic [INDEX_BITS-1:0]         rsp_char_index,
   output logic [INDEX_BITS-1:0]         rsp_start_offset,
   output logic                          rsp_last_of_run,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_utf8_mode
);

   localparam int unsigned CB = u8d_pkg::CODE_BITS;
   localparam int unsigned IB = INDEX_BITS;
   localparam int unsigned WW = CB + 1 + IB + IB + 1;

   // decoder state
   logic          mode_ff;
   logic [1:0]    pend_ff, pend_in;
   logic [CB-1:0] acc_ff, acc_in;
   logic [IB-1:0] bc_ff, bc_in;
   logic [IB-1:0] cc_ff, cc_in;
   logic [IB-1:0] ss_ff, ss_in;

   // state as seen by this byte, after a start of text
   logic [1:0]    pend0;
   logic [CB-1:0] acc0;
   logic [IB-1:0] bc0, cc0, ss0;

   logic          accept;
   logic [7:0]    b;
   logic          is_cont, is_ascii, is_l2, is_l3, is_l4, is_badlead;
   logic [1:0]    pend_m1;
   logic [CB-1:0] cont_sh, acc_cont;
   logic [CB-1:0] lead_code;
   logic          push0, push1, room2;
   logic [WW-1:0] word0, word1, word_out;

   assign accept    = req_valid && req_ready;
   assign req_ready = room2;
   assign csr_ready = 1'b1;
   assign b         = req_data_byte;

   // clear on start of text
   always_comb begin
      pend0 = req_start_of_text ? 2'd0 : pend_ff;
      acc0  = req_start_of_text ? '0 : acc_ff;
      bc0   = req_start_of_text ? '0 : bc_ff;
      cc0   = req_start_of_text ? '0 : cc_ff;
      ss0   = req_start_of_text ? '0 : ss_ff;
   end

   // byte classes
   always_comb begin
      is_cont    = (b & u8d_pkg::TOP2_MASK) == u8d_pkg::CONT_MATCH;
      is_ascii   = (b & u8d_pkg::TOP1_MASK) == 8'h00;
      is_l2      = (b & u8d_pkg::TOP3_MASK) == u8d_pkg::LEAD2_MATCH;
      is_l3      = (b & u8d_pkg::TOP4_MASK) == u8d_pkg::LEAD3_MATCH;
      is_l4      = (b & u8d_pkg::TOP5_MASK) == u8d_pkg::LEAD4_MATCH;
      is_badlead = !is_ascii && !is_l2 && !is_l3 && !is_l4;
      lead_code  = is_ascii ? CB'(b) : '0;
   end

   // continuation payload placed by bytes still expected after this one
   always_comb begin
      pend_m1 = pend0 - 2'd1;
      case (pend_m1)
         2'd0:    cont_sh = CB'(b & u8d_pkg::CONT_BITS);
         2'd1:    cont_sh = CB'(b & u8d_pkg::CONT_BITS) << 6;
         2'd2:    cont_sh = CB'(b & u8d_pkg::CONT_BITS) << 12;
         default: cont_sh = '0;
      endcase
      acc_cont = acc0 | cont_sh;
   end

   // decode: results and next state
   always_comb begin
      push0   = 1'b0;
      push1   = 1'b0;
      word0   = '0;
      word1   = '0;
      pend_in = 2'd0;
      acc_in  = '0;
      ss_in   = ss0;
      bc_in   = bc0 + IB'(1);
      if (mode_ff == u8d_pkg::MODE_PASS) begin
         push0 = 1'b1;
         word0 = {CB'(b), 1'b0, cc0, bc0, 1'b1};
      end else if (pend0 != 2'd0 && is_cont) begin
         pend_in = pend_m1;
         if (pend_m1 == 2'd0) begin
            push0 = 1'b1;
            word0 = {acc_cont, 1'b0, cc0, ss0, 1'b1};
         end else begin
            acc_in = acc_cont;
         end
      end else begin
         // broken sequence word first, then the byte as a new lead
         if (pend0 != 2'd0) begin
            push0 = 1'b1;
            word0 = {CB'(0), 1'b1, cc0, ss0, !(is_ascii || is_badlead)};
            if (is_ascii || is_badlead) begin
               push1 = 1'b1;
               word1 = {lead_code, is_badlead, cc0 + IB'(1), bc0, 1'b1};
            end
         end else if (is_ascii || is_badlead) begin
            push0 = 1'b1;
            word0 = {lead_code, is_badlead, cc0, bc0, 1'b1};
         end
         if (is_l2) begin
            pend_in = 2'd1;
            acc_in  = CB'(b & u8d_pkg::LEAD2_BITS) << 6;
            ss_in   = bc0;
         end else if (is_l3) begin
            pend_in = 2'd2;
            acc_in  = CB'(b & u8d_pkg::LEAD3_BITS) << 12;
            ss_in   = bc0;
         end else if (is_l4) begin
            pend_in = 2'd3;
            acc_in  = CB'(b & u8d_pkg::LEAD4_BITS) << 18;
            ss_in   = bc0;
         end
      end
      cc_in = cc0 + IB'(push0) + IB'(push1);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= u8d_pkg::MODE_UTF8;
         pend_ff <= 2'd0;
         acc_ff  <= '0;
         bc_ff   <= '0;
         cc_ff   <= '0;
         ss_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_utf8_mode;
         end
         if (accept) begin
            pend_ff <= pend_in;
            acc_ff  <= acc_in;
            bc_ff   <= bc_in;
            cc_ff   <= cc_in;
            ss_ff   <= ss_in;
         end
      end
   end

   // result queue
   u8d_rsp_queue #(
      .WIDTH (WW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (accept && push0),
      .push1     (accept && push1),
      .data0     (word0),
      .data1     (word1),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (word_out),
      .room2     (room2)
   );

   // unpack result word
   assign rsp_code_point   = word_out[WW-1 -: CB];
   assign rsp_bad_sequence = word_out[2*IB+1];
   assign rsp_char_index   = word_out[2*IB -: IB];
   assign rsp_start_offset = word_out[IB -: IB];
   assign rsp_last_of_run  = word_out[0];

endmodule

FILE: rtl/core/u8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the UTF-8 stream decoder, attached by bind.
// ----------------------------------------------------------------------------
module u8d_checker #(
   parameter int unsigned INDEX_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [u8d_pkg::CODE_BITS-1:0] rsp_code_point,
   input logic                          rsp_bad_sequence,
   input logic [INDEX_BITS-1:0]         rsp_char_index,
   input logic                          rsp_last_of_run
);

   // a bad word never carries a code
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_sequence) |-> (rsp_code_point == '0))
      else $error("bad word with nonzero code");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("word shown right after reset");

   // the second word of a pair is already queued with the first
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("second word of a pair missing");

   // a pending word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_char_index)))
      else $error("word dropped or changed while stalled");

endmodule

bind utf8_stream_decoder_core u8d_checker #(
   .INDEX_BITS (INDEX_BITS)
) u_u8d_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_code_point   (rsp_code_point),
   .rsp_bad_sequence (rsp_bad_sequence),
   .rsp_char_index   (rsp_char_index),
   .rsp_last_of_run  (rsp_last_of_run)
);
